>>> src/vfpq_pkg.sv
package vfpq_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;

    localparam int CMD_W    = 2;
    localparam int TIME_W   = 40;
    localparam int HANDLE_W = 16;
    localparam int PTS_W    = 33;
    localparam int GEN_W    = 16;
    localparam int KIND_W   = 3;
    localparam int THR_W    = 16;
    localparam int START_W  = 32;

    localparam logic [THR_W-1:0] THR_RESET = 16'd80;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_FLUSH   = 2'd2
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        EV_SHOWN    = 3'd0,
        EV_LATE     = 3'd1,
        EV_STALE    = 3'd2,
        EV_INVALID  = 3'd3,
        EV_OVERFLOW = 3'd4
    } t_event_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CHECK,
        ST_HEAD,
        ST_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic        load;
        logic        calc_target;
        logic        push;
        logic        pop;
        logic        flush;
        logic        emit;
        t_event_kind kind;
        logic        emit_frame;
        logic        finish;
    } t_ctrl;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             frame_stale;
        logic             frame_neg;
        logic             full;
        logic             empty;
        logic             one_left;
        logic             started;
        logic             target_neg;
        logic             head_stale;
        logic             head_neg;
        logic             head_late;
        logic             head_due;
    } t_stat;

endpackage

>>> src/vfpq_ctrl.sv
module vfpq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  vfpq_pkg::t_stat i_stat,
    output vfpq_pkg::t_ctrl o_ctrl,
    output logic            o_busy
);

    vfpq_pkg::t_state r_state;
    vfpq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vfpq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl = '0;
        o_ctrl.kind = vfpq_pkg::EV_SHOWN;
        case (r_state)
            vfpq_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_ctrl.load = 1'b1;
                    n_state = vfpq_pkg::ST_DISPATCH;
                end
            end
            vfpq_pkg::ST_DISPATCH: begin
                n_state = vfpq_pkg::ST_DONE;
                case (vfpq_pkg::t_cmd'(i_stat.cmd))
                    vfpq_pkg::CMD_ENQUEUE: begin
                        if (i_stat.frame_stale) begin
                            o_ctrl.emit = 1'b1;
                            o_ctrl.emit_frame = 1'b1;
                            o_ctrl.kind = vfpq_pkg::EV_STALE;
                        end else if (i_stat.frame_neg) begin
                            o_ctrl.emit = 1'b1;
                            o_ctrl.emit_frame = 1'b1;
                            o_ctrl.kind = vfpq_pkg::EV_INVALID;
                        end else begin
                            // A full queue gives up its oldest frame to make room.
                            o_ctrl.push = 1'b1;
                            if (i_stat.full) begin
                                o_ctrl.pop = 1'b1;
                                o_ctrl.emit = 1'b1;
                                o_ctrl.kind = vfpq_pkg::EV_OVERFLOW;
                            end
                        end
                    end
                    vfpq_pkg::CMD_TICK: begin
                        if (!i_stat.empty && i_stat.started) begin
                            o_ctrl.calc_target = 1'b1;
                            n_state = vfpq_pkg::ST_CHECK;
                        end
                    end
                    vfpq_pkg::CMD_FLUSH: begin
                        o_ctrl.flush = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            vfpq_pkg::ST_CHECK: begin
                n_state = i_stat.target_neg ? vfpq_pkg::ST_DONE : vfpq_pkg::ST_HEAD;
            end
            vfpq_pkg::ST_HEAD: begin
                if (i_stat.head_stale || i_stat.head_neg) begin
                    o_ctrl.pop = 1'b1;
                    o_ctrl.emit = 1'b1;
                    o_ctrl.kind = i_stat.head_stale ? vfpq_pkg::EV_STALE
                                                    : vfpq_pkg::EV_INVALID;
                    n_state = i_stat.one_left ? vfpq_pkg::ST_DONE : vfpq_pkg::ST_WAIT;
                end else if (i_stat.one_left || !i_stat.head_late) begin
                    if (i_stat.head_due) begin
                        o_ctrl.pop = 1'b1;
                        o_ctrl.emit = 1'b1;
                        o_ctrl.kind = vfpq_pkg::EV_SHOWN;
                    end
                    n_state = vfpq_pkg::ST_DONE;
                end else begin
                    o_ctrl.pop = 1'b1;
                    o_ctrl.emit = 1'b1;
                    o_ctrl.kind = vfpq_pkg::EV_LATE;
                    n_state = vfpq_pkg::ST_WAIT;
                end
            end
            vfpq_pkg::ST_WAIT: begin
                // The head slot read is registered, so the new head lands in the cycle after the pointer moves.
                n_state = vfpq_pkg::ST_HEAD;
            end
            vfpq_pkg::ST_DONE: begin
                o_ctrl.finish = 1'b1;
                n_state = vfpq_pkg::ST_IDLE;
            end
            default: begin
                n_state = vfpq_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != vfpq_pkg::ST_IDLE);

endmodule

>>> src/vfpq_dp.sv
module vfpq_dp #(
    parameter int QUEUE_DEPTH = vfpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [vfpq_pkg::THR_W-1:0]             i_cfg_wr_data,
    input  logic [vfpq_pkg::CMD_W-1:0]             i_cmd,
    input  logic [vfpq_pkg::TIME_W-1:0]            i_now_ms,
    input  logic [vfpq_pkg::HANDLE_W-1:0]          i_frame_handle,
    input  logic signed [vfpq_pkg::PTS_W-1:0]      i_frame_pts,
    input  logic [vfpq_pkg::GEN_W-1:0]             i_frame_generation,
    input  vfpq_pkg::t_ctrl                        i_ctrl,
    output vfpq_pkg::t_stat                        o_stat,
    output logic                                   o_strobe,
    output logic [vfpq_pkg::KIND_W-1:0]            o_event_kind,
    output logic [vfpq_pkg::HANDLE_W-1:0]          o_out_handle,
    output logic signed [vfpq_pkg::PTS_W-1:0]      o_out_pts,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]       o_queue_level,
    output logic                                   o_last_event
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int EW = vfpq_pkg::TIME_W + 1;
    localparam int TW = vfpq_pkg::TIME_W + 2;
    localparam int DW = TW + 1;
    localparam int PW = vfpq_pkg::PTS_W;

    // Frame slots.
    logic [PW-1:0]                   r_slot_pts    [QUEUE_DEPTH];
    logic [vfpq_pkg::GEN_W-1:0]      r_slot_gen    [QUEUE_DEPTH];
    logic [vfpq_pkg::HANDLE_W-1:0]   r_slot_handle [QUEUE_DEPTH];
    logic [PW-1:0]                   r_rd_pts;
    logic [vfpq_pkg::GEN_W-1:0]      r_rd_gen;
    logic [vfpq_pkg::HANDLE_W-1:0]   r_rd_handle;

    logic [AW-1:0]                   r_head;
    logic [CW-1:0]                   r_count;
    logic                            r_started;
    logic [vfpq_pkg::START_W-1:0]    r_start_pts;
    logic [vfpq_pkg::TIME_W-1:0]     r_start_time;
    logic [vfpq_pkg::GEN_W-1:0]      r_gen;
    logic [vfpq_pkg::THR_W-1:0]      r_thr;

    // Captured request.
    logic [vfpq_pkg::CMD_W-1:0]      r_cmd;
    logic [vfpq_pkg::HANDLE_W-1:0]   r_frame_handle;
    logic [PW-1:0]                   r_frame_pts;
    logic [vfpq_pkg::GEN_W-1:0]      r_frame_gen;
    logic signed [EW-1:0]            r_elapsed;
    logic signed [TW-1:0]            r_target;

    // The wall clock of the request is kept for latching the start time.
    logic [vfpq_pkg::TIME_W-1:0]     r_now_keep;

    // One result is held back until it is known whether another follows it.
    logic                            r_pend_valid;
    vfpq_pkg::t_event_kind           r_pend_kind;
    logic [vfpq_pkg::HANDLE_W-1:0]   r_pend_handle;
    logic [PW-1:0]                   r_pend_pts;
    logic [CW-1:0]                   r_pend_level;

    logic                            r_out_strobe;
    vfpq_pkg::t_event_kind           r_out_kind;
    logic [vfpq_pkg::HANDLE_W-1:0]   r_out_handle;
    logic [PW-1:0]                   r_out_pts;
    logic [CW-1:0]                   r_out_level;
    logic                            r_out_last;

    logic [SW-1:0]                   tail_sum;
    logic [AW-1:0]                   tail_idx;
    logic [AW-1:0]                   head_inc;
    logic [CW-1:0]                   n_count;
    logic signed [DW-1:0]            late_diff;
    logic signed [TW-1:0]            head_pts_ext;

    always_comb begin
        tail_sum = SW'(r_head) + SW'(r_count);
        if (tail_sum >= SW'(QUEUE_DEPTH)) begin
            tail_idx = AW'(tail_sum - SW'(QUEUE_DEPTH));
        end else begin
            tail_idx = AW'(tail_sum);
        end
        head_inc = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + AW'(1);
        n_count = r_count;
        if (i_ctrl.push && !i_ctrl.pop) begin
            n_count = r_count + CW'(1);
        end else if (i_ctrl.pop && !i_ctrl.push) begin
            n_count = r_count - CW'(1);
        end
        head_pts_ext = $signed({{(TW - PW){r_rd_pts[PW-1]}}, r_rd_pts});
        late_diff = $signed({r_target[TW-1], r_target})
                  - $signed({{(DW - PW){r_rd_pts[PW-1]}}, r_rd_pts});
    end

    always_comb begin
        o_stat.cmd         = r_cmd;
        o_stat.frame_stale = (r_frame_gen != r_gen);
        o_stat.frame_neg   = r_frame_pts[PW-1];
        o_stat.full        = (r_count == CW'(QUEUE_DEPTH));
        o_stat.empty       = (r_count == '0);
        o_stat.one_left    = (r_count == CW'(1));
        o_stat.started     = r_started;
        o_stat.target_neg  = r_target[TW-1];
        o_stat.head_stale  = (r_rd_gen != r_gen);
        o_stat.head_neg    = r_rd_pts[PW-1];
        o_stat.head_late   = late_diff > $signed({{(DW - vfpq_pkg::THR_W){1'b0}}, r_thr});
        o_stat.head_due    = head_pts_ext <= r_target;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_slot_pts[tail_idx]    <= r_frame_pts;
            r_slot_gen[tail_idx]    <= r_frame_gen;
            r_slot_handle[tail_idx] <= r_frame_handle;
        end
        r_rd_pts    <= r_slot_pts[r_head];
        r_rd_gen    <= r_slot_gen[r_head];
        r_rd_handle <= r_slot_handle[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd          <= i_cmd;
            r_frame_handle <= i_frame_handle;
            r_frame_pts    <= i_frame_pts;
            r_frame_gen    <= i_frame_generation;
            r_elapsed      <= $signed({1'b0, i_now_ms}) - $signed({1'b0, r_start_time});
        end
        if (i_ctrl.calc_target) begin
            r_target <= $signed({{(TW - vfpq_pkg::START_W){1'b0}}, r_start_pts})
                      + $signed({r_elapsed[EW-1], r_elapsed});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_count      <= '0;
            r_started    <= 1'b0;
            r_start_pts  <= '0;
            r_start_time <= '0;
            r_gen        <= '0;
            r_thr        <= vfpq_pkg::THR_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
            if (i_ctrl.flush) begin
                r_head       <= '0;
                r_count      <= '0;
                r_started    <= 1'b0;
                r_start_pts  <= '0;
                r_start_time <= '0;
                r_gen        <= r_gen + vfpq_pkg::GEN_W'(1);
            end else begin
                r_count <= n_count;
                if (i_ctrl.pop) begin
                    r_head <= head_inc;
                end
                if (i_ctrl.push && !r_started) begin
                    r_started    <= 1'b1;
                    r_start_pts  <= r_frame_pts[vfpq_pkg::START_W-1:0];
                    r_start_time <= r_now_keep;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_now_keep <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_strobe <= 1'b0;
        end else begin
            r_out_strobe <= (i_ctrl.emit || i_ctrl.finish) && r_pend_valid;
            if (i_ctrl.emit) begin
                r_pend_valid <= 1'b1;
            end else if (i_ctrl.finish) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit) begin
            r_pend_kind   <= i_ctrl.kind;
            r_pend_handle <= i_ctrl.emit_frame ? r_frame_handle : r_rd_handle;
            r_pend_pts    <= i_ctrl.emit_frame ? r_frame_pts : r_rd_pts;
            r_pend_level  <= n_count;
        end
        if (i_ctrl.emit || i_ctrl.finish) begin
            r_out_kind   <= r_pend_kind;
            r_out_handle <= r_pend_handle;
            r_out_pts    <= r_pend_pts;
            r_out_level  <= r_pend_level;
            r_out_last   <= i_ctrl.finish;
        end
    end

    assign o_strobe      = r_out_strobe;
    assign o_event_kind  = r_out_kind;
    assign o_out_handle  = r_out_handle;
    assign o_out_pts     = r_out_pts;
    assign o_queue_level = r_out_level;
    assign o_last_event  = r_out_last;

endmodule

>>> src/video_frame_pacing_queue_core.sv
// Frame pacing queue with a command interface: a request is taken when start is high
// and busy is low, and every result appears for exactly one cycle with o_strobe high,
// so the receiver must take it then; o_last_event marks the final result of a request.
// Enqueue, flush, an unused command and a tick with an empty queue or a stopped clock
// keep busy high through the dispatch and done states; a tick whose target is negative
// also passes the check state. Any other tick visits the check and head states, plus a
// wait state for every frame it drops before the one it stops at, for the registered
// read of the head slot. Each result is held back until the next result or
// the end of the request is known, so the last result of a request appears in the first
// cycle after busy falls. The threshold register may be written at any time the block
// is idle.
module video_frame_pacing_queue_core #(
    parameter int QUEUE_DEPTH = vfpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [vfpq_pkg::THR_W-1:0]             i_cfg_wr_data,
    input  logic                                   start,
    input  logic [vfpq_pkg::CMD_W-1:0]             i_cmd,
    input  logic [vfpq_pkg::TIME_W-1:0]            i_now_ms,
    input  logic [vfpq_pkg::HANDLE_W-1:0]          i_frame_handle,
    input  logic signed [vfpq_pkg::PTS_W-1:0]      i_frame_pts,
    input  logic [vfpq_pkg::GEN_W-1:0]             i_frame_generation,
    output logic                                   busy,
    output logic                                   o_strobe,
    output logic [vfpq_pkg::KIND_W-1:0]            o_event_kind,
    output logic [vfpq_pkg::HANDLE_W-1:0]          o_out_handle,
    output logic signed [vfpq_pkg::PTS_W-1:0]      o_out_pts,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]       o_queue_level,
    output logic                                   o_last_event
);

    vfpq_pkg::t_ctrl ctrl;
    vfpq_pkg::t_stat stat;

    vfpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (busy)
    );

    vfpq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_cmd              (i_cmd),
        .i_now_ms           (i_now_ms),
        .i_frame_handle     (i_frame_handle),
        .i_frame_pts        (i_frame_pts),
        .i_frame_generation (i_frame_generation),
        .i_ctrl             (ctrl),
        .o_stat             (stat),
        .o_strobe           (o_strobe),
        .o_event_kind       (o_event_kind),
        .o_out_handle       (o_out_handle),
        .o_out_pts          (o_out_pts),
        .o_queue_level      (o_queue_level),
        .o_last_event       (o_last_event)
    );

`ifndef SYNTH
    a_strobe_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a request in progress");

    a_more_follows_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_event) |-> busy)
        else $error("non-final result while the block is idle");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.pop |-> !stat.empty)
        else $error("pop from an empty queue");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_queue_level <= QUEUE_DEPTH))
        else $error("queue level beyond depth");
`endif

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import vfpq_pkg::*;

    localparam int QUEUE_DEPTH    = 8;
    localparam int SETTLE_CYCLES  = 3 + 2 * QUEUE_DEPTH + 5;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 5;
    localparam int PHASE_ITEMS    = 30;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        t_event_kind              kind;
        logic [HANDLE_W-1:0]      handle;
        logic signed [PTS_W-1:0]  pts;
        logic [3:0]               level;
        logic                     last;
    } pacing_event_t;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic [TIME_W-1:0]        now;
        logic [HANDLE_W-1:0]      handle;
        logic signed [PTS_W-1:0]  pts;
        logic [GEN_W-1:0]         gen;
        bit                       typed;
        pacing_event_t            want;
    } frame_req_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_wr_en;
    logic [THR_W-1:0]         i_cfg_wr_data;
    logic                     start;
    logic [CMD_W-1:0]         i_cmd;
    logic [TIME_W-1:0]        i_now_ms;
    logic [HANDLE_W-1:0]      i_frame_handle;
    logic signed [PTS_W-1:0]  i_frame_pts;
    logic [GEN_W-1:0]         i_frame_generation;
    logic                     busy;
    logic                     o_strobe;
    logic [KIND_W-1:0]        o_event_kind;
    logic [HANDLE_W-1:0]      o_out_handle;
    logic signed [PTS_W-1:0]  o_out_pts;
    logic [3:0]               o_queue_level;
    logic                     o_last_event;

    video_frame_pacing_queue_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .start              (start),
        .i_cmd              (i_cmd),
        .i_now_ms           (i_now_ms),
        .i_frame_handle     (i_frame_handle),
        .i_frame_pts        (i_frame_pts),
        .i_frame_generation (i_frame_generation),
        .busy               (busy),
        .o_strobe           (o_strobe),
        .o_event_kind       (o_event_kind),
        .o_out_handle       (o_out_handle),
        .o_out_pts          (o_out_pts),
        .o_queue_level      (o_queue_level),
        .o_last_event       (o_last_event)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the pacing queue, its playback clock and the threshold.
    logic signed [PTS_W-1:0]  q_pts [QUEUE_DEPTH];
    logic [GEN_W-1:0]         q_gen [QUEUE_DEPTH];
    logic [HANDLE_W-1:0]      q_handle [QUEUE_DEPTH];
    int                       q_head;
    int                       q_count;
    bit                       clock_running;
    logic [START_W-1:0]       anchor_pts;
    logic [TIME_W-1:0]        anchor_time;
    logic [GEN_W-1:0]         live_gen;
    logic [THR_W-1:0]         late_thr;

    pacing_event_t            step_events[$];
    pacing_event_t            expected_events[$];
    pacing_event_t            oldest_event;
    int                       mismatch_count;
    int                       idle_cycles;
    int                       burst_left;

    function automatic void log_event(input t_event_kind k, input logic [HANDLE_W-1:0] h,
                                      input logic signed [PTS_W-1:0] p);
        pacing_event_t ev;
        ev.kind   = k;
        ev.handle = h;
        ev.pts    = p;
        ev.level  = 4'(q_count);
        ev.last   = 1'b0;
        step_events.push_back(ev);
    endfunction

    function automatic void drop_head();
        if (q_count > 0) begin
            q_head  = (q_head + 1) % QUEUE_DEPTH;
            q_count = q_count - 1;
        end
    endfunction

    // Fills step_events with the events that one request causes.
    function automatic void predict_pacing_events(input frame_req_t rq);
        longint                   target;
        longint                   hp;
        int                       tail;
        bit                       evicted;
        logic [HANDLE_W-1:0]      ev_handle;
        logic signed [PTS_W-1:0]  ev_pts;
        logic [HANDLE_W-1:0]      hh;
        step_events.delete();
        case (rq.cmd)
            CMD_ENQUEUE: begin
                if (rq.gen != live_gen) begin
                    log_event(EV_STALE, rq.handle, rq.pts);
                end else if (rq.pts < 0) begin
                    log_event(EV_INVALID, rq.handle, rq.pts);
                end else begin
                    evicted = 1'b0;
                    if (q_count >= QUEUE_DEPTH) begin
                        ev_handle = q_handle[q_head];
                        ev_pts    = q_pts[q_head];
                        evicted   = 1'b1;
                        drop_head();
                    end
                    tail           = (q_head + q_count) % QUEUE_DEPTH;
                    q_pts[tail]    = rq.pts;
                    q_gen[tail]    = rq.gen;
                    q_handle[tail] = rq.handle;
                    q_count        = q_count + 1;
                    if (evicted)
                        log_event(EV_OVERFLOW, ev_handle, ev_pts);
                    if (!clock_running) begin
                        clock_running = 1'b1;
                        anchor_pts    = rq.pts[START_W-1:0];
                        anchor_time   = rq.now;
                    end
                end
            end
            CMD_TICK: begin
                if (q_count > 0 && clock_running) begin
                    target = longint'({32'b0, anchor_pts})
                           + (longint'({24'b0, rq.now}) - longint'({24'b0, anchor_time}));
                    if (target >= 0) begin
                        while (q_count > 0) begin
                            hp = longint'(q_pts[q_head]);
                            hh = q_handle[q_head];
                            if (q_gen[q_head] != live_gen) begin
                                drop_head();
                                log_event(EV_STALE, hh, q_pts[(q_head + QUEUE_DEPTH - 1)
                                                              % QUEUE_DEPTH]);
                                continue;
                            end
                            if (hp < 0) begin
                                drop_head();
                                log_event(EV_INVALID, hh, PTS_W'(hp));
                                continue;
                            end
                            if (q_count <= 1)
                                break;
                            if (target - hp <= longint'({48'b0, late_thr}))
                                break;
                            drop_head();
                            log_event(EV_LATE, hh, PTS_W'(hp));
                        end
                        if (q_count > 0) begin
                            hp = longint'(q_pts[q_head]);
                            hh = q_handle[q_head];
                            if (q_gen[q_head] != live_gen) begin
                                drop_head();
                                log_event(EV_STALE, hh, PTS_W'(hp));
                            end else if (hp < 0) begin
                                drop_head();
                                log_event(EV_INVALID, hh, PTS_W'(hp));
                            end else if (hp <= target) begin
                                drop_head();
                                log_event(EV_SHOWN, hh, PTS_W'(hp));
                            end
                        end
                    end
                end
            end
            CMD_FLUSH: begin
                q_head        = 0;
                q_count       = 0;
                clock_running = 1'b0;
                anchor_pts    = '0;
                anchor_time   = '0;
                live_gen      = live_gen + 1'b1;
            end
            default: ;
        endcase
        if (step_events.size() > 0)
            step_events[step_events.size() - 1].last = 1'b1;
    endfunction

    function automatic frame_req_t row(input logic [CMD_W-1:0] c, input logic [TIME_W-1:0] t,
                                       input logic [HANDLE_W-1:0] h,
                                       input logic signed [PTS_W-1:0] p,
                                       input logic [GEN_W-1:0] g);
        frame_req_t r;
        r.cmd    = c;
        r.now    = t;
        r.handle = h;
        r.pts    = p;
        r.gen    = g;
        r.typed  = 1'b0;
        r.want   = '{EV_SHOWN, '0, '0, '0, 1'b0};
        return r;
    endfunction

    // A row whose single result is written out by hand.
    function automatic frame_req_t typed_row(input frame_req_t r, input t_event_kind k,
                                             input logic [HANDLE_W-1:0] h,
                                             input logic signed [PTS_W-1:0] p,
                                             input logic [3:0] lvl);
        frame_req_t t;
        t       = r;
        t.typed = 1'b1;
        t.want  = '{k, h, p, lvl, 1'b1};
        return t;
    endfunction

    // Drives one request and waits until it is taken; the sender works in bursts with gaps.
    task automatic issue_request(input frame_req_t rq);
        @(negedge i_clk);
        if (burst_left == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 6);
        end
        if (burst_left > 0)
            burst_left = burst_left - 1;
        i_cmd              = rq.cmd;
        i_now_ms           = rq.now;
        i_frame_handle     = rq.handle;
        i_frame_pts        = rq.pts;
        i_frame_generation = rq.gen;
        start              = 1'b1;
        do @(posedge i_clk); while (busy);
        predict_pacing_events(rq);
        if (rq.typed) begin
            step_events.delete();
            step_events.push_back(rq.want);
        end
        foreach (step_events[i])
            expected_events.push_back(step_events[i]);
    endtask

    // The threshold is only written once the block has gone quiet.
    task automatic write_threshold(input logic [THR_W-1:0] value);
        @(negedge i_clk);
        start = 1'b0;
        while (expected_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        late_thr      = value;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else if (i_rst_n && o_strobe) begin
            if (expected_events.size() == 0) begin
                $error("result with no request pending: kind %0d handle %0d",
                       o_event_kind, o_out_handle);
                mismatch_count = mismatch_count + 1;
            end else begin
                oldest_event = expected_events.pop_front();
                if (o_event_kind !== oldest_event.kind) begin
                    $error("event_kind: expected %0d, got %0d", oldest_event.kind, o_event_kind);
                    mismatch_count = mismatch_count + 1;
                end
                if (o_out_handle !== oldest_event.handle) begin
                    $error("out_handle: expected %0d, got %0d", oldest_event.handle,
                           o_out_handle);
                    mismatch_count = mismatch_count + 1;
                end
                if (o_out_pts !== oldest_event.pts) begin
                    $error("out_pts: expected %0d, got %0d", oldest_event.pts, o_out_pts);
                    mismatch_count = mismatch_count + 1;
                end
                if (o_queue_level !== oldest_event.level) begin
                    $error("queue_level: expected %0d, got %0d", oldest_event.level,
                           o_queue_level);
                    mismatch_count = mismatch_count + 1;
                end
                if (o_last_event !== oldest_event.last) begin
                    $error("last_event: expected %0d, got %0d", oldest_event.last,
                           o_last_event);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    initial begin
        frame_req_t               directed[$];
        frame_req_t               rq;
        logic [THR_W-1:0]         phase_thr [PHASES];
        logic [TIME_W-1:0]        wall_ms;
        logic signed [PTS_W-1:0]  pts_cursor;
        int                       counted;
        int                       pick;

        i_rst_n            = 1'b0;
        i_cfg_wr_en        = 1'b0;
        i_cfg_wr_data      = '0;
        start              = 1'b0;
        i_cmd              = CMD_ENQUEUE;
        i_now_ms           = '0;
        i_frame_handle     = '0;
        i_frame_pts        = '0;
        i_frame_generation = '0;
        q_head             = 0;
        q_count            = 0;
        clock_running      = 1'b0;
        anchor_pts         = '0;
        anchor_time        = '0;
        live_gen           = '0;
        late_thr           = THR_RESET;
        mismatch_count     = 0;
        idle_cycles        = 0;
        burst_left         = 0;
        foreach (q_pts[i]) begin
            q_pts[i]    = '0;
            q_gen[i]    = '0;
            q_handle[i] = '0;
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        directed.push_back(typed_row(row(CMD_ENQUEUE, 40'd0, 16'd0, 33'sd0, 16'hFFFF),
                                     EV_STALE, 16'd0, 33'sd0, 4'd0));
        directed.push_back(typed_row(row(CMD_ENQUEUE, 40'd0, 16'hFFFF, -33'sd2147483648,
                                         16'd0),
                                     EV_INVALID, 16'hFFFF, -33'sd2147483648, 4'd0));
        directed.push_back(row(CMD_TICK, 40'd100, 16'd0, 33'sd0, 16'd0));
        directed.push_back(row(CMD_UNUSED, 40'hFF_FFFF_FFFF, 16'hFFFF, -33'sd1, 16'hFFFF));
        directed.push_back(row(CMD_ENQUEUE, 40'd5000, 16'd1, 33'sd1000, 16'd0));
        // Wall clock before the start point: the target goes negative.
        directed.push_back(row(CMD_TICK, 40'd3000, 16'd0, 33'sd0, 16'd0));
        directed.push_back(row(CMD_TICK, 40'd5000, 16'd0, 33'sd0, 16'd0));
        directed.push_back(row(CMD_ENQUEUE, 40'd5100, 16'd16, 33'sd1100, 16'd0));
        directed.push_back(row(CMD_ENQUEUE, 40'd5100, 16'd17, 33'sd1133, 16'd0));
        directed.push_back(row(CMD_ENQUEUE, 40'd5100, 16'd18, 33'sd1166, 16'd0));
        directed.push_back(row(CMD_ENQUEUE, 40'd5100, 16'd19, 33'sd1200, 16'd0));
        directed.push_back(row(CMD_ENQUEUE, 40'd5100, 16'd20, 33'sd1233, 16'd0));
        directed.push_back(row(CMD_ENQUEUE, 40'd5100, 16'd21, 33'sd1266, 16'd0));
        directed.push_back(row(CMD_ENQUEUE, 40'd5100, 16'd22, 33'sd1300, 16'd0));
        directed.push_back(row(CMD_ENQUEUE, 40'd5100, 16'd23, 33'sd4294967295, 16'd0));
        // Ninth frame on a full queue pushes out the oldest one.
        directed.push_back(typed_row(row(CMD_ENQUEUE, 40'd5200, 16'd24, 33'sd1400, 16'd0),
                                     EV_OVERFLOW, 16'd16, 33'sd1100, 4'd8));
        directed.push_back(row(CMD_TICK, 40'd5250, 16'd0, 33'sd0, 16'd0));
        directed.push_back(row(CMD_TICK, 40'd5250, 16'd0, 33'sd0, 16'd0));
        directed.push_back(row(CMD_TICK, 40'd5250, 16'd0, 33'sd0, 16'd0));
        directed.push_back(row(CMD_FLUSH, 40'd0, 16'd0, 33'sd0, 16'd0));
        directed.push_back(row(CMD_ENQUEUE, 40'hFF_FFFF_FFFF, 16'hFFFF, 33'sd4294967295,
                               16'd1));
        directed.push_back(row(CMD_TICK, 40'hFF_FFFF_FFFF, 16'd0, 33'sd0, 16'd0));
        directed.push_back(row(CMD_FLUSH, 40'd0, 16'd0, 33'sd0, 16'd0));

        foreach (directed[i])
            issue_request(directed[i]);

        phase_thr  = '{16'd0, 16'hFFFF, THR_W'($urandom_range(1, 65534)), 16'd80, 16'd20};
        wall_ms    = 40'd10000;
        pts_cursor = 33'sd500;
        for (int ph = 0; ph < PHASES; ph++) begin
            write_threshold(phase_thr[ph]);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                rq = row(CMD_TICK, wall_ms, HANDLE_W'($urandom), 33'sd0, live_gen);
                if (pick < 45) begin
                    rq.cmd = CMD_ENQUEUE;
                    if (pick < 3) begin
                        rq.pts = {1'b0, 32'($urandom)};
                    end else begin
                        rq.pts     = pts_cursor;
                        pts_cursor = pts_cursor + $urandom_range(10, 50);
                    end
                    wall_ms = wall_ms + $urandom_range(0, 20);
                end else if (pick < 80) begin
                    wall_ms = wall_ms + ((pick < 48) ? $urandom_range(100, 2000)
                                                     : $urandom_range(0, 60));
                    rq.now  = wall_ms;
                end else if (pick < 85) begin
                    rq.cmd     = CMD_FLUSH;
                    pts_cursor = PTS_W'($urandom_range(0, 100000));
                    wall_ms    = wall_ms + $urandom_range(0, 30);
                end else if (pick < 90) begin
                    rq.cmd = CMD_ENQUEUE;
                    rq.pts = pts_cursor;
                    rq.gen = live_gen + GEN_W'($urandom_range(1, 65535));
                end else if (pick < 95) begin
                    rq.cmd = CMD_ENQUEUE;
                    rq.pts = {2'b11, 31'($urandom)};
                end else if (pick < 98) begin
                    rq.now = {8'($urandom), 32'($urandom)};
                end else begin
                    rq.cmd = CMD_UNUSED;
                    rq.now = {8'($urandom), 32'($urandom)};
                    rq.pts = PTS_W'({$urandom, $urandom});
                    rq.gen = GEN_W'($urandom);
                end
                issue_request(rq);
                if (rq.cmd != CMD_UNUSED)
                    counted = counted + 1;
            end
        end

        @(negedge i_clk);
        start = 1'b0;
        while (expected_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
